// ===== sv/csem_pkg.sv =====
// Shared constants, codes and handshake structs for the counting semaphore.
`timescale 1ns / 1ps

package csem_pkg;

    // Default sizing
    localparam int DEF_MAX_WAITERS    = 16;
    localparam int DEF_COUNT_BITS     = 16;
    localparam int DEF_WAITER_ID_BITS = 8;

    // Field widths on the ports
    localparam int CMD_W      = 2;
    localparam int ID_FIELD_W = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 16;
    localparam int QLEN_W     = 5;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WAIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRYWAIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POST    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_GRANTED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QUEUED      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_WOULD_BLOCK = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TIMED_OUT   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_QUEUE_FULL  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_SATURATED   = 3'd5;

    // Register index (paddr[2])
    localparam logic REG_INITIAL_COUNT = 1'b0;

    // Control state of the top level
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    // Requests to the waiter queue
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic cancel;
    } q_req_t;

    // Cancel scan outcome
    typedef struct packed {
        logic done;
        logic found;
    } q_rsp_t;

endpackage

// ===== sv/csem_queue.sv =====
// Waiter queue: circular buffer in a synchronous memory with a cancel scan.
`timescale 1ns / 1ps

module csem_queue import csem_pkg::*; #(
    parameter int MAX_WAITERS    = DEF_MAX_WAITERS,
    parameter int WAITER_ID_BITS = DEF_WAITER_ID_BITS,
    localparam int CNT_W = $clog2(MAX_WAITERS + 1),
    localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  q_req_t                    req,
    input  logic [WAITER_ID_BITS-1:0] id,
    output q_rsp_t                    rsp,
    output logic [WAITER_ID_BITS-1:0] pop_data,
    output logic [CNT_W-1:0]          total
);

    logic [WAITER_ID_BITS-1:0] mem [MAX_WAITERS];
    logic [WAITER_ID_BITS-1:0] rd_data_reg;

    logic [IDX_W-1:0]          head_reg;
    logic [CNT_W-1:0]          total_reg;
    logic                      scan_reg;
    logic [CNT_W-1:0]          pos_reg;
    logic                      chk_valid_reg;
    logic [CNT_W-1:0]          chk_pos_reg;
    logic                      found_reg;
    logic [WAITER_ID_BITS-1:0] id_reg;

    logic                      scan_issue;
    logic                      scan_done;
    logic                      match;
    logic                      shift_wr;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [WAITER_ID_BITS-1:0] wr_data;

    // Map a queue position to a memory slot
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(MAX_WAITERS)) begin
            sum = sum - (CNT_W+1)'(MAX_WAITERS);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Scan control: read one entry a cycle, check it the next
    assign scan_issue = scan_reg && (pos_reg < total_reg);
    assign scan_done  = scan_reg && !scan_issue && !chk_valid_reg;
    assign match      = chk_valid_reg && !found_reg && (rd_data_reg == id_reg);
    assign shift_wr   = chk_valid_reg && found_reg;

    // Port muxes
    assign rd_en   = req.pop || scan_issue;
    assign rd_addr = req.pop ? head_reg : slot(head_reg, pos_reg);
    assign wr_en   = req.push || shift_wr;
    assign wr_addr = req.push ? slot(head_reg, total_reg)
                              : slot(head_reg, chk_pos_reg - CNT_W'(1));
    assign wr_data = req.push ? id : rd_data_reg;

    // Memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Pointers and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            total_reg     <= '0;
            scan_reg      <= 1'b0;
            pos_reg       <= '0;
            chk_valid_reg <= 1'b0;
            chk_pos_reg   <= '0;
            found_reg     <= 1'b0;
        end else if (req.clear) begin
            head_reg      <= '0;
            total_reg     <= '0;
            scan_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            if (req.push) begin
                total_reg <= total_reg + CNT_W'(1);
            end
            if (req.pop) begin
                head_reg  <= slot(head_reg, CNT_W'(1));
                total_reg <= total_reg - CNT_W'(1);
            end
            if (req.cancel) begin
                scan_reg      <= 1'b1;
                pos_reg       <= '0;
                chk_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
                id_reg        <= id;
            end else if (scan_reg) begin
                chk_valid_reg <= scan_issue;
                if (scan_issue) begin
                    chk_pos_reg <= pos_reg;
                    pos_reg     <= pos_reg + CNT_W'(1);
                end
                if (match) begin
                    found_reg <= 1'b1;
                end
                if (scan_done) begin
                    scan_reg <= 1'b0;
                    if (found_reg) begin
                        total_reg <= total_reg - CNT_W'(1);
                    end
                end
            end
        end
    end

    assign rsp.done  = scan_done;
    assign rsp.found = found_reg;
    assign pop_data  = rd_data_reg;
    assign total     = total_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(MAX_WAITERS))
        else $error("waiter count above capacity");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        req.push |-> total_reg < CNT_W'(MAX_WAITERS))
        else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.pop |-> total_reg != '0)
        else $error("pop from empty queue");

    a_shift_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_wr |-> chk_pos_reg != '0)
        else $error("shift write without an earlier match");
`endif

endmodule

// ===== sv/counting_semaphore_fifo_waiters.sv =====
// Top level: counting semaphore with a FIFO wait queue, stream and APB ports.
//
//  Channel | Dir | Handshake         | Payload
//  s_      | in  | s_tvalid/s_tready | tuser: command; tdata: waiter_id
//  m_      | out | m_tvalid/m_tready | tdata: status .. queue_empty
//  apb     | cfg | psel/penable      | initial_count at byte address 0
//
// Wait, trywait and post without a waiter finish in the idle state; post with a
// waiter passes through S_POP for one memory read of the queue head; cancel passes
// through S_SCAN, whose scan reads one queued entry a cycle.
// Reset is synchronous and active low; count and queue come up empty.
// One result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module counting_semaphore_fifo_waiters import csem_pkg::*; #(
    parameter int MAX_WAITERS    = DEF_MAX_WAITERS,
    parameter int COUNT_BITS     = DEF_COUNT_BITS,
    parameter int WAITER_ID_BITS = DEF_WAITER_ID_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [7:0] waiter_id
    input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] status, [3] woken_valid, [11:4] woken_id, [27:12] count_now,
    // [32:28] queue_length, [33] queue_empty
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    state_t                    state_reg, state_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]        init_reg, init_next;
    logic                      res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic                      res_woken_reg, res_woken_next;
    logic [ID_FIELD_W-1:0]     res_id_reg, res_id_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]       m_tdata_reg, m_tdata_next;

    q_req_t                    q_req;
    q_rsp_t                    q_rsp;
    logic [WAITER_ID_BITS-1:0] q_pop_data;
    logic [CNT_W-1:0]          q_total;

    logic                      s_xfer;
    logic                      cfg_wr;
    logic [WAITER_ID_BITS+ID_FIELD_W-1:0] id_ext;
    logic [WAITER_ID_BITS+ID_FIELD_W-1:0] woken_ext;
    logic [COUNT_BITS+COUNT_W-1:0]        cfg_count_ext;
    logic [COUNT_BITS+COUNT_W-1:0]        count_out_ext;
    logic [CNT_W+QLEN_W-1:0]              qlen_ext;

    // Width adaption of the fields
    assign id_ext        = {{WAITER_ID_BITS{1'b0}}, s_tdata[ID_FIELD_W-1:0]};
    assign woken_ext     = {{ID_FIELD_W{1'b0}}, q_pop_data};
    assign cfg_count_ext = {{COUNT_BITS{1'b0}}, pwdata[COUNT_W-1:0]};
    assign count_out_ext = {{COUNT_W{1'b0}}, count_reg};
    assign qlen_ext      = {{QLEN_W{1'b0}}, q_total};

    assign s_tready = (state_reg == S_IDLE) && !res_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_INITIAL_COUNT)
                      ? {{(APB_DATA_W-COUNT_W){1'b0}}, init_reg} : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    csem_queue #(
        .MAX_WAITERS   (MAX_WAITERS),
        .WAITER_ID_BITS(WAITER_ID_BITS)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .id      (id_ext[WAITER_ID_BITS-1:0]),
        .rsp     (q_rsp),
        .pop_data(q_pop_data),
        .total   (q_total)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        init_next       = init_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_woken_next  = res_woken_reg;
        res_id_next     = res_id_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        q_req           = '0;

        // Move a finished result into the output register
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid_reg && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_next  = 1'b1;
            m_tdata_next   = {6'b0, (q_total == '0), qlen_ext[QLEN_W-1:0],
                              count_out_ext[COUNT_W-1:0], res_id_reg,
                              res_woken_reg, res_status_reg};
            res_valid_next = 1'b0;
        end

        // Command sequencing
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    res_woken_next  = 1'b0;
                    res_id_next     = '0;
                    res_status_next = STAT_GRANTED;
                    case (s_tuser)
                        CMD_WAIT: begin
                            res_valid_next = 1'b1;
                            if (count_reg != '0) begin
                                count_next = count_reg - COUNT_BITS'(1);
                            end else if (q_total < CNT_W'(MAX_WAITERS)) begin
                                q_req.push      = 1'b1;
                                res_status_next = STAT_QUEUED;
                            end else begin
                                res_status_next = STAT_QUEUE_FULL;
                            end
                        end
                        CMD_TRYWAIT: begin
                            res_valid_next = 1'b1;
                            if (count_reg != '0) begin
                                count_next = count_reg - COUNT_BITS'(1);
                            end else begin
                                res_status_next = STAT_WOULD_BLOCK;
                            end
                        end
                        CMD_POST: begin
                            if (q_total != '0) begin
                                q_req.pop  = 1'b1;
                                state_next = S_POP;
                            end else if (count_reg == COUNT_MAX) begin
                                res_valid_next  = 1'b1;
                                res_status_next = STAT_SATURATED;
                            end else begin
                                res_valid_next = 1'b1;
                                count_next     = count_reg + COUNT_BITS'(1);
                            end
                        end
                        CMD_CANCEL: begin
                            q_req.cancel = 1'b1;
                            state_next   = S_SCAN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                res_valid_next  = 1'b1;
                res_status_next = STAT_GRANTED;
                res_woken_next  = 1'b1;
                res_id_next     = woken_ext[ID_FIELD_W-1:0];
                state_next      = S_IDLE;
            end
            S_SCAN: begin
                if (q_rsp.done) begin
                    res_valid_next  = 1'b1;
                    res_status_next = q_rsp.found ? STAT_TIMED_OUT : STAT_GRANTED;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration write reloads the count and drops all waiters
        if (cfg_wr && (paddr[2] == REG_INITIAL_COUNT)) begin
            init_next   = pwdata[COUNT_W-1:0];
            count_next  = cfg_count_ext[COUNT_BITS-1:0];
            q_req.clear = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            init_reg      <= '0;
            res_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            init_reg      <= init_next;
            res_valid_reg <= res_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_woken_reg  <= res_woken_next;
        res_id_reg     <= res_id_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

// ===== verif/tb_counting_semaphore_fifo_waiters.sv =====
// Self-checking testbench for the counting semaphore with its FIFO wait queue.
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_waiters import csem_pkg::*;;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 100;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
    localparam logic [ADDR_W-1:0] INIT_COUNT_ADDR = {REG_INITIAL_COUNT, 2'b00};

    // One result transfer, split into its fields
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  woken_valid;
        logic [ID_FIELD_W-1:0] woken_id;
        logic [COUNT_W-1:0]    count_now;
        logic [QLEN_W-1:0]     queue_length;
        logic                  queue_empty;
    } sem_result_t;

    // Mirror of the semaphore state plus the queue of results still owed
    class sem_scoreboard;
        logic [COUNT_W-1:0]    count;
        logic [ID_FIELD_W-1:0] waiters[$];
        sem_result_t           owed[$];
        int                    errors;

        function new();
            count  = '0;
            errors = 0;
        endfunction

        // Register write re-initializes: new count, empty queue
        function void load_count(logic [COUNT_W-1:0] value);
            count = value;
            waiters.delete();
        endfunction

        // Advance the mirror by one accepted request and store its result
        function void note_request(logic [CMD_W-1:0] cmd, logic [ID_FIELD_W-1:0] id);
            sem_result_t r;
            int          hit;
            r      = '0;
            hit    = -1;
            r.status = STAT_GRANTED;
            case (cmd)
                CMD_WAIT: begin
                    if (count != 0) begin
                        count = count - 1'b1;
                    end else if (waiters.size() < DEF_MAX_WAITERS) begin
                        waiters.push_back(id);
                        r.status = STAT_QUEUED;
                    end else begin
                        r.status = STAT_QUEUE_FULL;
                    end
                end
                CMD_TRYWAIT: begin
                    if (count != 0) count = count - 1'b1;
                    else r.status = STAT_WOULD_BLOCK;
                end
                CMD_POST: begin
                    // A queued waiter takes the unit directly
                    if (waiters.size() != 0) begin
                        r.woken_valid = 1'b1;
                        r.woken_id    = waiters.pop_front();
                    end else if (count == COUNT_TOP) begin
                        r.status = STAT_SATURATED;
                    end else begin
                        count = count + 1'b1;
                    end
                end
                default: begin
                    // Drop only the oldest matching waiter; no match means already woken
                    foreach (waiters[i]) if (hit < 0 && waiters[i] == id) hit = i;
                    if (hit >= 0) begin
                        waiters.delete(hit);
                        r.status = STAT_TIMED_OUT;
                    end
                end
            endcase
            r.count_now    = count;
            r.queue_length = QLEN_W'(waiters.size());
            r.queue_empty  = (waiters.size() == 0);
            owed.push_back(r);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
            end
        endfunction

        // Compare one result transfer against the oldest stored result
        function void check_result(logic [M_DATA_W-1:0] data);
            sem_result_t e;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t ns: result %0h arrived with nothing outstanding", $time, data);
                return;
            end
            e = owed.pop_front();
            report("status", 32'(e.status), 32'(data[2:0]));
            report("woken_valid", 32'(e.woken_valid), 32'(data[3]));
            report("woken_id", 32'(e.woken_id), 32'(data[11:4]));
            report("count_now", 32'(e.count_now), 32'(data[27:12]));
            report("queue_length", 32'(e.queue_length), 32'(data[32:28]));
            report("queue_empty", 32'(e.queue_empty), 32'(data[33]));
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // [7:0] waiter_id
    logic [CMD_W-1:0]      s_tuser;   // [1:0] command
    logic                  m_tvalid;
    logic                  m_tready;
    // [2:0] status, [3] woken_valid, [11:4] woken_id, [27:12] count_now,
    // [32:28] queue_length, [33] queue_empty
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sem_scoreboard sb;
    int            cycles;
    int            stall_left;
    bit            tx_calm;
    bit            rx_calm;

    counting_semaphore_fifo_waiters dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("counting_semaphore_fifo_waiters verification failed");
            $finish;
        end
    end

    // Stall the result channel at random unless in a calm stretch
    always @(posedge aclk) begin
        if (rx_calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            m_tready <= 1'b0;
            stall_left <= gap_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Offer one request and hold it until the transfer
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [ID_FIELD_W-1:0] id);
        s_tuser  <= cmd;
        s_tdata  <= id;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(cmd, id);
    endtask

    // Send a request, then maybe idle the input channel
    task automatic push_item(logic [CMD_W-1:0] cmd, logic [ID_FIELD_W-1:0] id);
        int n;
        send_request(cmd, id);
        n = tx_calm ? 0 : gap_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Hold off input until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Write initial_count, then read it back
    task automatic write_initial_count(logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INIT_COUNT_ADDR;
        pwdata  <= {{(APB_DATA_W-COUNT_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.load_count(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.report("prdata", {{(APB_DATA_W-COUNT_W){1'b0}}, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One configuration setting followed by weighted random requests
    task automatic run_phase(logic [COUNT_W-1:0] init, int w_wait, int w_try, int w_post,
                             int w_cancel, logic [ID_FIELD_W-1:0] id_base, int id_span,
                             int pause_at);
        int                    r;
        logic [CMD_W-1:0]      cmd;
        logic [ID_FIELD_W-1:0] id;
        drain();
        write_initial_count(init);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 25 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == pause_at) drain();
            r = $urandom_range(0, w_wait + w_try + w_post + w_cancel - 1);
            if (r < w_wait) cmd = CMD_WAIT;
            else if (r < w_wait + w_try) cmd = CMD_TRYWAIT;
            else if (r < w_wait + w_try + w_post) cmd = CMD_POST;
            else cmd = CMD_CANCEL;
            // Small id pool gives duplicates and cancel hits
            if ($urandom_range(0, 9) < 7) id = id_base + ID_FIELD_W'($urandom_range(0, id_span));
            else id = ID_FIELD_W'($urandom_range(0, 255));
            push_item(cmd, id);
        end
    endtask

    initial begin
        sb         = new();
        cycles     = 0;
        stall_left = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_WAIT;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty semaphore, queueing, cancel, wake order
        push_item(CMD_TRYWAIT, 8'h5A);
        push_item(CMD_WAIT, 8'h00);
        push_item(CMD_WAIT, 8'hFF);
        push_item(CMD_WAIT, 8'h00);
        push_item(CMD_CANCEL, 8'h00);
        push_item(CMD_CANCEL, 8'h4D);
        push_item(CMD_POST, 8'hFF);
        push_item(CMD_POST, 8'h00);
        push_item(CMD_POST, 8'hA5);
        push_item(CMD_WAIT, 8'h11);
        push_item(CMD_POST, 8'h00);
        push_item(CMD_TRYWAIT, 8'hFF);

        // Directed: saturation at the top count, cancel on an empty queue
        drain();
        write_initial_count(COUNT_TOP);
        push_item(CMD_POST, 8'h00);
        push_item(CMD_TRYWAIT, 8'h00);
        push_item(CMD_POST, 8'hFF);
        push_item(CMD_POST, 8'h3C);
        push_item(CMD_CANCEL, 8'h03);

        // Random phases over several counts, queue-heavy and post-heavy
        run_phase(16'h0000, 55, 10, 15, 20, 8'h00, 5, -1);
        run_phase(COUNT_TOP, 10, 15, 60, 15, 8'hF8, 7, -1);
        run_phase(16'h0001, 35, 15, 30, 20, 8'h60, 3, 50);
        run_phase(COUNT_W'($urandom_range(2, 65533)), 25, 25, 25, 25,
                  ID_FIELD_W'($urandom_range(0, 255)), 7, -1);
        run_phase(16'hFFFE, 15, 20, 50, 15, 8'hA0, 4, 30);
        run_phase(16'h0000, 60, 5, 15, 20, 8'h00, 3, -1);

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("counting_semaphore_fifo_waiters verification clean");
        end else begin
            $display("counting_semaphore_fifo_waiters verification failed");
        end
        $finish;
    end

endmodule
